[hdl/pvapg_pkg.sv]
package pvapg_pkg;

  // Number of voice cells in the chain.
  localparam int VOICES = 8;

  // Voices below this index have a playing bit on the input.
  localparam int PLAY_BITS = 8;

  localparam int SAMPLE_W = 7;
  localparam int NOTE_W   = 7;
  localparam int VOICE_W  = 3;
  localparam int GAIN_W   = 16;

  // floor(n / 127) == (n * GAIN_RECIP) >> GAIN_SHIFT for every n below 2^15.
  localparam int GAIN_RECIP = 33027;
  localparam int GAIN_SHIFT = 22;

  typedef enum logic [1:0] {
    OP_NOTE_ON    = 2'd0,
    OP_NOTE_OFF   = 2'd1,
    OP_AFTERTOUCH = 2'd2,
    OP_UNUSED     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_GAIN    = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_GAIN = 1'b1
  } state_t;

  // Event broadcast to every voice cell.
  typedef struct packed {
    logic                accept;
    opcode_t             op;
    logic [SAMPLE_W-1:0] sample_id;
    logic [NOTE_W-1:0]   note;
    logic                loaded;
  } cell_cmd_t;

endpackage

[hdl/pvapg_voice_cell.sv]
module pvapg_voice_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pvapg_pkg::cell_cmd_t  cmd,
  input  logic                  playing,
  input  logic                  claim_in,
  output logic                  claim_out,
  output logic                  take
);
  import pvapg_pkg::*;

  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [NOTE_W-1:0]   note_r, note_nxt;
  logic [SAMPLE_W-1:0] eff_sample;
  logic                on_off;
  logic                hit;

  // Note-on and note-off of a loaded sample first free voices whose player went idle.
  assign on_off     = ((cmd.op == OP_NOTE_ON) || (cmd.op == OP_NOTE_OFF)) && cmd.loaded;
  assign eff_sample = (on_off && !playing) ? '0 : sample_r;

  always_comb begin
    hit = 1'b0;
    case (cmd.op)
      OP_NOTE_ON:    hit = cmd.loaded && (eff_sample == '0);
      OP_NOTE_OFF:   hit = cmd.loaded && (eff_sample == cmd.sample_id) &&
                           (note_r == cmd.note);
      OP_AFTERTOUCH: hit = (sample_r == cmd.sample_id);
      default:       hit = 1'b0;
    endcase
  end

  assign take      = hit && !claim_in;
  assign claim_out = claim_in || hit;

  always_comb begin
    sample_nxt = eff_sample;
    note_nxt   = note_r;
    if (take && (cmd.op == OP_NOTE_ON)) begin
      sample_nxt = cmd.sample_id;
      note_nxt   = cmd.note;
    end else if (take && (cmd.op == OP_NOTE_OFF)) begin
      sample_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      note_r   <= '0;
    end else if (cmd.accept) begin
      sample_r <= sample_nxt;
      note_r   <= note_nxt;
    end
  end

endmodule

[hdl/pvapg_gain.sv]
module pvapg_gain (
  input  logic                         clk,
  input  logic                         load,
  input  logic [6:0]                   velocity,
  input  logic [6:0]                   pan,
  output logic [pvapg_pkg::GAIN_W-1:0] gain_left,
  output logic [pvapg_pkg::GAIN_W-1:0] gain_right
);
  import pvapg_pkg::*;

  logic [6:0]        vel_r;
  logic [12:0]       vp_r;
  logic              far_left_r;
  logic [5:0]        p;
  logic [14:0]       n;
  logic [30:0]       prod;
  logic [GAIN_W-1:0] near;
  logic [GAIN_W-1:0] far;
  logic [1:0]        near_corr;

  // For pan at or above center the far factor 127 - pan equals the inverted low bits.
  assign p = pan[6] ? ~pan[5:0] : pan[5:0];

  always_ff @(posedge clk) begin
    if (load) begin
      vel_r      <= velocity;
      vp_r       <= 13'(velocity * p);
      far_left_r <= pan[6];
    end
  end

  // 32768 / 127 = 258 + 2 / 127, so only a small correction remains.
  always_comb begin
    if (vel_r == 7'd127) begin
      near_corr = 2'd2;
    end else if (vel_r[6]) begin
      near_corr = 2'd1;
    end else begin
      near_corr = 2'd0;
    end
  end

  assign near = {1'b0, vel_r, 8'b0} + {8'b0, vel_r, 1'b0} + {14'b0, near_corr};

  // 512 / 127 = 4 + 4 / 127; the fractional part goes through a reciprocal multiply.
  assign n    = {vp_r, 2'b00};
  assign prod = {16'b0, n} * 31'(GAIN_RECIP);
  assign far  = {1'b0, n} + {7'b0, prod[30:GAIN_SHIFT]};

  assign gain_left  = far_left_r ? far : near;
  assign gain_right = far_left_r ? near : far;

endmodule

[hdl/poly_voice_allocator_pan_gain.sv]
// Voice allocator for live sample playback with a fixed chain of voice cells. At the
// transfer edge the event runs down the cell chain, the first matching cell claims it
// and, on a note-on, updates its sample and note (a note-off clears its sample), and
// velocity times the far pan factor is captured; then, in the gain state, the pan-law
// gains are finished by a reciprocal multiply and loaded into the output register once
// it is free. A new item is accepted as soon as the block is back in idle, also while
// the previous result still waits to be taken. Every voice is free right after reset,
// with no clearing pass. opcode travels on in_tuser and action on out_tuser.
module poly_voice_allocator_pan_gain (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sample_id[6:0], note[13:7], base_note[20:14], velocity[27:21], pan[34:28],
  // reverse_in[35], scratch_in[36], voices_playing[44:37], sample_loaded[45], zero[47:46]
  input  logic [47:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // voice[2:0], gain_left[18:3], gain_right[34:19], base_note_out[41:35],
  // note_out[48:42], reverse_out[49], scratch_out[50], zero[55:51]
  output logic [55:0] out_tdata,
  // action[1:0]
  output logic [1:0]  out_tuser
);
  import pvapg_pkg::*;

  logic        in_xfer;
  cell_cmd_t   cmd;
  logic [7:0]  playing_in;
  logic [6:0]  base_in, vel_in, pan_in;
  logic        rev_in, scr_in;

  logic [VOICES:0]   claim;
  logic [VOICES-1:0] take;
  logic [VOICES-1:0] cell_play;
  logic [VOICE_W-1:0] voice_idx;

  state_t  state_r, state_nxt;
  action_t act_r, act_nxt;
  logic [VOICE_W-1:0] voice_r;
  logic [6:0]  base_r, note_r;
  logic        rev_r, scr_r;
  logic        start_nxt;

  logic [GAIN_W-1:0] gain_left, gain_right;
  logic              out_load;
  logic              out_valid_r;
  logic [55:0]       out_data_r;
  action_t           out_act_r;
  logic              gains_on;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign cmd.accept    = in_xfer;
  assign cmd.op        = opcode_t'(in_tuser);
  assign cmd.sample_id = in_tdata[6:0];
  assign cmd.note      = in_tdata[13:7];
  assign cmd.loaded    = in_tdata[45];
  assign base_in       = in_tdata[20:14];
  assign vel_in        = in_tdata[27:21];
  assign pan_in        = in_tdata[34:28];
  assign rev_in        = in_tdata[35];
  assign scr_in        = in_tdata[36];
  assign playing_in    = in_tdata[44:37];

  assign claim[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < VOICES; gi++) begin : g_cell
      if (gi < PLAY_BITS) begin : g_play
        assign cell_play[gi] = playing_in[gi];
      end else begin : g_noplay
        assign cell_play[gi] = 1'b0;
      end

      pvapg_voice_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .playing   (cell_play[gi]),
        .claim_in  (claim[gi]),
        .claim_out (claim[gi+1]),
        .take      (take[gi])
      );
    end
  endgenerate

  always_comb begin
    voice_idx = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (take[i]) begin
        voice_idx = voice_idx | VOICE_W'(i);
      end
    end
  end

  always_comb begin
    act_nxt = ACT_NONE;
    case (cmd.op)
      OP_NOTE_ON:    act_nxt = claim[VOICES] ? ACT_START : ACT_NONE;
      OP_NOTE_OFF:   act_nxt = claim[VOICES] ? ACT_RELEASE : ACT_NONE;
      OP_AFTERTOUCH: act_nxt = claim[VOICES] ? ACT_GAIN : ACT_NONE;
      default:       act_nxt = ACT_NONE;
    endcase
  end

  assign start_nxt = (act_nxt == ACT_START);

  pvapg_gain u_gain (
    .clk        (clk),
    .load       (in_xfer),
    .velocity   (vel_in),
    .pan        (pan_in),
    .gain_left  (gain_left),
    .gain_right (gain_right)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r   <= act_nxt;
      voice_r <= voice_idx;
      base_r  <= start_nxt ? base_in : '0;
      note_r  <= start_nxt ? cmd.note : '0;
      rev_r   <= start_nxt && rev_in;
      scr_r   <= start_nxt && scr_in;
    end
  end

  // The finished result waits in the gain state while the output register is still full.
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign gains_on = (act_r == ACT_START) || (act_r == ACT_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_act_r  <= act_r;
      out_data_r <= {5'b0, scr_r, rev_r, note_r, base_r,
                     gains_on ? gain_right : '0,
                     gains_on ? gain_left : '0,
                     voice_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_act_r;

  a_take_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(take))
    else $error("more than one voice cell claimed the event");

  a_accept_to_gain: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_GAIN))
    else $error("accepted item did not move to the gain state");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_tuser == ACT_NONE)) |-> (out_tdata == '0))
    else $error("empty result carries nonzero fields");

  a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_tuser == ACT_RELEASE)) |-> (out_tdata[55:3] == '0))
    else $error("release carries nonzero gain or note fields");

  a_no_claim_no_voice: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !claim[VOICES]) |=> ((act_r == ACT_NONE) && (voice_r == '0)))
    else $error("event without a claiming voice produced an action");

endmodule

[tb/sv/tb_poly_voice_allocator_pan_gain.sv]
`timescale 1ns / 100ps

module tb_poly_voice_allocator_pan_gain;
  import pvapg_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_OFF_LEN  = 400;
  localparam int HOLD_OFF_AT   = 500;
  localparam int RANDOM_EVENTS = 830;

  typedef struct packed {
    opcode_t             op;
    logic [SAMPLE_W-1:0] sample_id;
    logic [NOTE_W-1:0]   note;
    logic [NOTE_W-1:0]   base_note;
    logic [6:0]          velocity;
    logic [6:0]          pan;
    logic                reverse_in;
    logic                scratch_in;
    logic [7:0]          voices_playing;
    logic                sample_loaded;
  } voice_event_t;

  typedef struct packed {
    action_t           action;
    logic [VOICE_W-1:0] voice;
    logic [GAIN_W-1:0] gain_left;
    logic [GAIN_W-1:0] gain_right;
    logic [NOTE_W-1:0] base_note_out;
    logic [NOTE_W-1:0] note_out;
    logic              reverse_out;
    logic              scratch_out;
  } voice_action_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = OP_NOTE_ON;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  voice_event_t  pending_events[$];
  voice_action_t expected_actions[$];
  voice_event_t  offered;

  // Predicted voice table: sample id (zero when free) and note per voice.
  logic [SAMPLE_W-1:0] slot_sample[VOICES];
  logic [NOTE_W-1:0]   slot_note[VOICES];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  hold_cycles  = 0;
  int  quiet_cycles = 0;
  bit  no_gaps      = 1'b0;

  poly_voice_allocator_pan_gain i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Pan law: full velocity gain on the near side, scaled by distance from the edge on the
  // far side. Both are truncated to Q1.15.
  function automatic void pan_gains(input logic [6:0] velocity, input logic [6:0] pan,
                                    output logic [GAIN_W-1:0] gain_left,
                                    output logic [GAIN_W-1:0] gain_right);
    int near_g;
    int far_g;
    int far_scale;
    near_g    = (int'(velocity) * 32768) / 127;
    far_scale = (pan < 64) ? int'(pan) : 127 - int'(pan);
    far_g     = (int'(velocity) * far_scale * 512) / 127;
    if (pan < 64) begin
      gain_left  = near_g[GAIN_W-1:0];
      gain_right = far_g[GAIN_W-1:0];
    end else begin
      gain_left  = far_g[GAIN_W-1:0];
      gain_right = near_g[GAIN_W-1:0];
    end
  endfunction

  function automatic voice_action_t apply_voice_event(input voice_event_t ev);
    voice_action_t act;
    bit            done;
    act  = '0;
    done = 1'b0;
    if ((ev.op == OP_NOTE_ON || ev.op == OP_NOTE_OFF) && ev.sample_loaded) begin
      for (int i = 0; i < VOICES; i++) begin
        if (i >= PLAY_BITS || !ev.voices_playing[i]) slot_sample[i] = '0;
      end
      for (int i = 0; i < VOICES && !done; i++) begin
        if (ev.op == OP_NOTE_ON && slot_sample[i] == '0) begin
          slot_sample[i]    = ev.sample_id;
          slot_note[i]      = ev.note;
          act.action        = ACT_START;
          act.voice         = i[VOICE_W-1:0];
          pan_gains(ev.velocity, ev.pan, act.gain_left, act.gain_right);
          act.base_note_out = ev.base_note;
          act.note_out      = ev.note;
          act.reverse_out   = ev.reverse_in;
          act.scratch_out   = ev.scratch_in;
          done = 1'b1;
        end else if (ev.op == OP_NOTE_OFF && slot_sample[i] == ev.sample_id &&
                     slot_note[i] == ev.note) begin
          slot_sample[i] = '0;
          act.action     = ACT_RELEASE;
          act.voice      = i[VOICE_W-1:0];
          done = 1'b1;
        end
      end
    end else if (ev.op == OP_AFTERTOUCH) begin
      for (int i = 0; i < VOICES && !done; i++) begin
        if (slot_sample[i] == ev.sample_id) begin
          act.action = ACT_GAIN;
          act.voice  = i[VOICE_W-1:0];
          pan_gains(ev.velocity, ev.pan, act.gain_left, act.gain_right);
          done = 1'b1;
        end
      end
    end
    return act;
  endfunction

  task automatic push_event(input opcode_t op, input int sample_id, input int note,
                            input int base_note, input int velocity, input int pan,
                            input bit reverse_in, input bit scratch_in,
                            input logic [7:0] playing, input bit loaded);
    voice_event_t ev;
    ev.op             = op;
    ev.sample_id      = sample_id[SAMPLE_W-1:0];
    ev.note           = note[NOTE_W-1:0];
    ev.base_note      = base_note[NOTE_W-1:0];
    ev.velocity       = velocity[6:0];
    ev.pan            = pan[6:0];
    ev.reverse_in     = reverse_in;
    ev.scratch_in     = scratch_in;
    ev.voices_playing = playing;
    ev.sample_loaded  = loaded;
    pending_events.push_back(ev);
  endtask

  // Sender: a new item is put up only once the current one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_actions.push_back(apply_voice_event(offered));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() > 0 && (no_gaps || $urandom_range(99) >= 35)) begin
          offered = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= offered.op;
          in_tdata  <= {2'b00, offered.sample_loaded, offered.voices_playing,
                        offered.scratch_in, offered.reverse_in, offered.pan,
                        offered.velocity, offered.base_note, offered.note,
                        offered.sample_id};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer against the oldest prediction, and once in the run
  // holds off long enough for the block to back up into its input.
  always @(posedge clk) begin
    voice_action_t got;
    voice_action_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.action        = action_t'(out_tuser);
        got.voice         = out_tdata[2:0];
        got.gain_left     = out_tdata[18:3];
        got.gain_right    = out_tdata[34:19];
        got.base_note_out = out_tdata[41:35];
        got.note_out      = out_tdata[48:42];
        got.reverse_out   = out_tdata[49];
        got.scratch_out   = out_tdata[50];
        if (expected_actions.size() == 0) begin
          if (mismatches < 10) begin
            $display("result %0d: none expected, got action %0d voice %0d",
                     results_seen, got.action, got.voice);
          end
          mismatches++;
        end else begin
          want = expected_actions.pop_front();
          if (got.action !== want.action || got.voice !== want.voice ||
              got.gain_left !== want.gain_left || got.gain_right !== want.gain_right ||
              got.base_note_out !== want.base_note_out ||
              got.note_out !== want.note_out || got.reverse_out !== want.reverse_out ||
              got.scratch_out !== want.scratch_out) begin
            if (mismatches < 10) begin
              $display("result %0d: expected act %0d voice %0d gl %0d gr %0d base %0d",
                       results_seen, want.action, want.voice, want.gain_left,
                       want.gain_right, want.base_note_out);
              $display("  note %0d rev %0b scr %0b; got act %0d voice %0d gl %0d gr %0d",
                       want.note_out, want.reverse_out, want.scratch_out, got.action,
                       got.voice, got.gain_left, got.gain_right);
              $display("  base %0d note %0d rev %0b scr %0b", got.base_note_out,
                       got.note_out, got.reverse_out, got.scratch_out);
            end
            mismatches++;
          end
        end
        results_seen++;
        if (results_seen == HOLD_OFF_AT) hold_cycles = HOLD_OFF_LEN;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_gaps || $urandom_range(99) >= 35;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] busy;
    logic [7:0] playing;
    opcode_t    op;
    int         sid;
    int         note;
    int         pick;
    int         r;

    for (int i = 0; i < VOICES; i++) begin
      slot_sample[i] = '0;
      slot_note[i]   = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every voice with extreme gains and flags, then exercise the corner cases.
    push_event(OP_NOTE_ON,    1,  60,  60, 127,  64, 0, 0, 8'hFF, 1);
    push_event(OP_NOTE_ON,    2, 127,   0, 127,   0, 1, 1, 8'hFF, 1);
    push_event(OP_NOTE_ON,  127,   0, 127, 127, 127, 0, 1, 8'hFF, 1);
    push_event(OP_NOTE_ON,    3,   5,  33, 127,  63, 1, 0, 8'hFF, 1);
    push_event(OP_NOTE_ON,    4,  40,  12,   0,   1, 0, 0, 8'hFF, 1);
    // Not loaded: ignored, and the zero playing mask must not free anything.
    push_event(OP_NOTE_ON,    5,  41,  41, 100,  20, 1, 1, 8'h00, 0);
    push_event(OP_NOTE_ON,    5,  41,  41,   1,  65, 1, 1, 8'hFF, 1);
    push_event(OP_NOTE_ON,    6,  85,  85,  64, 126, 0, 0, 8'hFF, 1);
    push_event(OP_NOTE_ON,    7,  42,  85,  90,  32, 1, 0, 8'hFF, 1);
    // All eight voices are busy now.
    push_event(OP_NOTE_ON,    8,  10,  10, 100,  64, 0, 0, 8'hFF, 1);
    push_event(OP_AFTERTOUCH, 127, 3,   3, 100,  30, 1, 1, 8'h00, 0);
    push_event(OP_AFTERTOUCH, 99,  3,   3, 100,  30, 0, 0, 8'hFF, 1);
    push_event(OP_NOTE_OFF,   1,  61,   0,  50,  50, 0, 0, 8'hFF, 1);
    push_event(OP_NOTE_OFF,   1,  60,   0,  50,  50, 1, 1, 8'hFF, 1);
    push_event(OP_NOTE_OFF,   2, 127,   0,  50,  50, 0, 0, 8'h00, 0);
    push_event(OP_UNUSED,     2, 127, 127, 127, 127, 1, 1, 8'hFF, 1);
    // Sample id zero lands in a voice that still counts as free.
    push_event(OP_NOTE_ON,    0,  10,  20, 127,  64, 1, 1, 8'hFE, 1);
    push_event(OP_AFTERTOUCH, 0,  10,  20,  77,  99, 0, 0, 8'hFF, 1);
    push_event(OP_NOTE_OFF,   0,  10,  20,  10,  10, 0, 0, 8'hFE, 1);
    push_event(OP_NOTE_OFF,   4,  40,   0,  10,  10, 0, 0, 8'hF0, 1);
    push_event(OP_NOTE_ON,    9,  99,   9, 127, 127, 0, 1, 8'h00, 1);
    push_event(OP_NOTE_OFF,   9,   9,   9,   5,   5, 0, 0, 8'h00, 1);

    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      while (pending_events.size() >= 2) @(negedge clk);
      no_gaps = (n >= 300 && n < 420);
      for (int i = 0; i < 8; i++) busy[i] = (slot_sample[i] != '0);
      r  = $urandom_range(99);
      op = (r < 45) ? OP_NOTE_ON : (r < 75) ? OP_NOTE_OFF :
           (r < 93) ? OP_AFTERTOUCH : OP_UNUSED;
      sid  = $urandom_range(1) ? $urandom_range(1, 6) : $urandom_range(127);
      note = $urandom_range(127);
      // Mostly keep the busy voices sounding so the table fills up and offs find hits.
      r = $urandom_range(99);
      if (r < 70) playing = busy;
      else if (r < 85) playing = busy & ~(8'd1 << $urandom_range(7));
      else playing = 8'($urandom);
      pick = $urandom_range(7);
      if (op != OP_NOTE_ON && slot_sample[pick] != '0 && $urandom_range(3) != 0) begin
        sid = slot_sample[pick];
        if (op == OP_NOTE_OFF) note = slot_note[pick];
      end
      push_event(op, sid, note, $urandom_range(127), $urandom_range(127),
                 $urandom_range(127), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 playing, $urandom_range(9) != 0);
    end
    no_gaps = 1'b0;

    while (pending_events.size() != 0 || in_tvalid || expected_actions.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[poly_voice_allocator_pan_gain.f]
hdl/pvapg_pkg.sv
hdl/pvapg_voice_cell.sv
hdl/pvapg_gain.sv
hdl/poly_voice_allocator_pan_gain.sv
tb/sv/tb_poly_voice_allocator_pan_gain.sv
